/* design/kcl_pkg.sv */
// Shared types and constants of the keypad code lock.
package kcl_pkg;

    typedef enum logic [1:0] {
        MODE_ENTRY      = 2'd0,
        MODE_UNLOCKED   = 2'd1,
        MODE_LOCKED_OUT = 2'd2,
        MODE_ALARM      = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        EV_NONE         = 3'd0,
        EV_DIGIT        = 3'd1,
        EV_CORRECT      = 3'd2,
        EV_WRONG        = 3'd3,
        EV_LOCKOUT      = 3'd4,
        EV_ALARM        = 3'd5,
        EV_LOCKOUT_OVER = 3'd6,
        EV_IGNORED      = 3'd7
    } t_event;

    typedef enum logic [1:0] {
        REG_SECRET_CODE     = 2'd0,
        REG_LOCKOUT_SECONDS = 2'd1,
        REG_LOCKOUT_ATTEMPT = 2'd2,
        REG_ALARM_ATTEMPT   = 2'd3
    } t_reg_idx;

    localparam logic [31:0] SECRET_CODE_RST     = 32'd951236;
    localparam logic [7:0]  LOCKOUT_SECONDS_RST = 8'd20;
    localparam logic [2:0]  LOCKOUT_ATTEMPT_RST = 3'd3;
    localparam logic [2:0]  ALARM_ATTEMPT_RST   = 3'd4;
    localparam logic [2:0]  ATTEMPT_MAX         = 3'd7;

    localparam logic [7:0]  KEY_ZERO  = 8'h30;
    localparam logic [7:0]  KEY_NINE  = 8'h39;
    localparam logic [7:0]  KEY_ENTER = 8'h3d;

    localparam int unsigned OUT_TDATA_W = 24;

    typedef struct packed {
        logic [31:0] secret_code;
        logic [7:0]  lockout_seconds;
        logic [2:0]  lockout_attempt;
        logic [2:0]  alarm_attempt;
    } t_cfg;

    typedef struct packed {
        logic [2:0] attempt_count;
        logic [7:0] seconds_remaining;
        logic       is_locked_out;
        logic       alarm_on;
        logic       is_unlocked;
        t_event     event_res;
    } t_result;

endpackage

/* design/keypad_code_lock_unit.sv */
// Top level of the keypad code lock: input register, lock core, result register.
// Each accepted word (a key or a one-second tick) yields exactly one result word.
// The input register feeds the lock core, whose whole state update is one
// combinational pass, and the core's result is then captured in an output
// register; with the output free a word is accepted every cycle, so one word
// per cycle is sustained.
// The output register holds a stalled result; the next word can still enter the input register while it is empty.
// Configure through the APB port only while no word is in flight.
module keypad_code_lock_unit #(
    parameter int unsigned MAX_DIGITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] key_char
    input  logic        s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [kcl_pkg::OUT_TDATA_W-1:0] m_axis_tdata, // [2:0] event_res,
        // [3] is_unlocked, [4] alarm_on, [5] is_locked_out,
        // [13:6] seconds_remaining, [16:14] attempt_count, [23:17] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    kcl_pkg::t_cfg    w_cfg;
    kcl_pkg::t_result w_result;

    logic       r_in_valid;
    logic       r_in_action;
    logic [7:0] r_in_key;
    logic       r_out_valid;
    kcl_pkg::t_result r_out;
    logic       w_step;

    assign w_step        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_step;

    kcl_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    kcl_core #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_action (r_in_action),
        .i_key    (r_in_key),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_action <= s_axis_tuser;
            r_in_key    <= s_axis_tdata;
        end
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.attempt_count, r_out.seconds_remaining,
                            r_out.is_locked_out, r_out.alarm_on, r_out.is_unlocked,
                            r_out.event_res};

endmodule

/* design/kcl_cfg_regs.sv */
// Configuration register file of the keypad code lock with its APB-style port.
module kcl_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output kcl_pkg::t_cfg o_cfg
);

    kcl_pkg::t_cfg    r_cfg;
    kcl_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = kcl_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.secret_code     <= kcl_pkg::SECRET_CODE_RST;
            r_cfg.lockout_seconds <= kcl_pkg::LOCKOUT_SECONDS_RST;
            r_cfg.lockout_attempt <= kcl_pkg::LOCKOUT_ATTEMPT_RST;
            r_cfg.alarm_attempt   <= kcl_pkg::ALARM_ATTEMPT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                kcl_pkg::REG_SECRET_CODE:     r_cfg.secret_code     <= pwdata;
                kcl_pkg::REG_LOCKOUT_SECONDS: r_cfg.lockout_seconds <= pwdata[7:0];
                kcl_pkg::REG_LOCKOUT_ATTEMPT: r_cfg.lockout_attempt <= pwdata[2:0];
                kcl_pkg::REG_ALARM_ATTEMPT:   r_cfg.alarm_attempt   <= pwdata[2:0];
                default:                      r_cfg                 <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            kcl_pkg::REG_SECRET_CODE:     prdata = r_cfg.secret_code;
            kcl_pkg::REG_LOCKOUT_SECONDS: prdata = {24'd0, r_cfg.lockout_seconds};
            kcl_pkg::REG_LOCKOUT_ATTEMPT: prdata = {29'd0, r_cfg.lockout_attempt};
            kcl_pkg::REG_ALARM_ATTEMPT:   prdata = {29'd0, r_cfg.alarm_attempt};
            default:                      prdata = 32'd0;
        endcase
    end

endmodule

/* design/kcl_core.sv */
// Lock state registers and the combinational update for one word.
module kcl_core #(
    parameter int unsigned MAX_DIGITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_action,
    input  logic [7:0]       i_key,
    input  kcl_pkg::t_cfg    i_cfg,
    output kcl_pkg::t_result o_result
);

    localparam int unsigned CntW = $clog2(MAX_DIGITS + 1);
    localparam logic [CntW-1:0] DigitsMax = CntW'(MAX_DIGITS);

    kcl_pkg::t_mode  r_mode, n_mode;
    logic [31:0]     r_value, n_value;
    logic [CntW-1:0] r_digits, n_digits;
    logic [2:0]      r_wrong, n_wrong;
    logic [7:0]      r_countdown, n_countdown;
    kcl_pkg::t_event w_event;

    logic        w_is_digit, w_is_enter, w_match, w_hit_lockout, w_hit_alarm;
    logic        w_digits_full, w_cd_done;
    logic [2:0]  w_wrong_inc;
    logic [7:0]  w_cd_dec;
    logic [31:0] w_value_ext;

    assign w_is_digit    = (i_key >= kcl_pkg::KEY_ZERO) && (i_key <= kcl_pkg::KEY_NINE);
    assign w_is_enter    = (i_key == kcl_pkg::KEY_ENTER);
    assign w_match       = (r_value == i_cfg.secret_code);
    assign w_wrong_inc   = (r_wrong == kcl_pkg::ATTEMPT_MAX) ? r_wrong : r_wrong + 3'd1;
    assign w_hit_lockout = (w_wrong_inc == i_cfg.lockout_attempt);
    assign w_hit_alarm   = (w_wrong_inc >= i_cfg.alarm_attempt);
    assign w_digits_full = (r_digits == DigitsMax);
    assign w_cd_dec      = (r_countdown != 8'd0) ? r_countdown - 8'd1 : 8'd0;
    assign w_cd_done     = (w_cd_dec == 8'd0);
    assign w_value_ext   = (r_value << 3) + (r_value << 1)
                           + {28'd0, i_key[3:0] - kcl_pkg::KEY_ZERO[3:0]};

    // Next mode.
    always_comb begin
        n_mode = r_mode;
        if (i_action) begin
            if (r_mode == kcl_pkg::MODE_LOCKED_OUT && w_cd_done) begin
                n_mode = kcl_pkg::MODE_ENTRY;
            end
        end else if (r_mode == kcl_pkg::MODE_ENTRY && w_is_enter) begin
            priority if (w_match) begin
                n_mode = kcl_pkg::MODE_UNLOCKED;
            end else if (w_hit_lockout) begin
                n_mode = kcl_pkg::MODE_LOCKED_OUT;
            end else if (w_hit_alarm) begin
                n_mode = kcl_pkg::MODE_ALARM;
            end else begin
                n_mode = kcl_pkg::MODE_ENTRY;
            end
        end
    end

    // Event code and data state.
    always_comb begin
        w_event     = kcl_pkg::EV_NONE;
        n_value     = r_value;
        n_digits    = r_digits;
        n_wrong     = r_wrong;
        n_countdown = r_countdown;
        if (i_action) begin
            if (r_mode == kcl_pkg::MODE_LOCKED_OUT) begin
                n_countdown = w_cd_dec;
                w_event     = w_cd_done ? kcl_pkg::EV_LOCKOUT_OVER : kcl_pkg::EV_NONE;
            end
        end else if (r_mode != kcl_pkg::MODE_ENTRY) begin
            w_event = kcl_pkg::EV_IGNORED;
        end else if (w_is_digit) begin
            if (w_digits_full) begin
                w_event = kcl_pkg::EV_IGNORED;
            end else begin
                n_value  = w_value_ext;
                n_digits = r_digits + CntW'(1);
                w_event  = kcl_pkg::EV_DIGIT;
            end
        end else if (w_is_enter) begin
            n_value  = 32'd0;
            n_digits = '0;
            priority if (w_match) begin
                n_wrong = 3'd0;
                w_event = kcl_pkg::EV_CORRECT;
            end else if (w_hit_lockout) begin
                n_wrong     = w_wrong_inc;
                n_countdown = i_cfg.lockout_seconds;
                w_event     = kcl_pkg::EV_LOCKOUT;
            end else if (w_hit_alarm) begin
                n_wrong = w_wrong_inc;
                w_event = kcl_pkg::EV_ALARM;
            end else begin
                n_wrong = w_wrong_inc;
                w_event = kcl_pkg::EV_WRONG;
            end
        end else begin
            w_event = kcl_pkg::EV_IGNORED;
        end
        if (n_mode != kcl_pkg::MODE_LOCKED_OUT) begin
            n_countdown = 8'd0;
        end
    end

    always_comb begin
        o_result.event_res         = w_event;
        o_result.is_unlocked       = (n_mode == kcl_pkg::MODE_UNLOCKED);
        o_result.alarm_on          = (n_mode == kcl_pkg::MODE_ALARM);
        o_result.is_locked_out     = (n_mode == kcl_pkg::MODE_LOCKED_OUT);
        o_result.seconds_remaining = n_countdown;
        o_result.attempt_count     = n_wrong;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= kcl_pkg::MODE_ENTRY;
            r_value     <= 32'd0;
            r_digits    <= '0;
            r_wrong     <= 3'd0;
            r_countdown <= 8'd0;
        end else if (i_step) begin
            r_mode      <= n_mode;
            r_value     <= n_value;
            r_digits    <= n_digits;
            r_wrong     <= n_wrong;
            r_countdown <= n_countdown;
        end
    end

    a_unlock_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == kcl_pkg::MODE_UNLOCKED |=> r_mode == kcl_pkg::MODE_UNLOCKED)
        else $error("unlocked mode was left");

    a_alarm_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == kcl_pkg::MODE_ALARM |=> r_mode == kcl_pkg::MODE_ALARM)
        else $error("alarm mode was left");

    a_countdown_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != kcl_pkg::MODE_LOCKED_OUT |-> r_countdown == 8'd0)
        else $error("countdown nonzero outside lockout");

    a_digits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digits <= DigitsMax)
        else $error("digit count beyond limit");

endmodule

/* sim/kcl_checker.sv */
// Checker for the keypad code lock: tracks the lock state and checks every result word.
module kcl_checker #(
    parameter int unsigned MAX_DIGITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [7:0]                      i_in_data,
    input  logic                            i_in_user,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [kcl_pkg::OUT_TDATA_W-1:0] i_out_data,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic                            i_pready,
    input  logic [3:0]                      i_paddr,
    input  logic [31:0]                     i_pwdata,
    output int                              o_pending,
    output int                              o_errors
);

    kcl_pkg::t_cfg    lock_cfg;
    kcl_pkg::t_mode   lock_mode;
    logic [31:0]      entry_value;
    logic [4:0]       entry_digits;
    logic [2:0]       misses;
    logic [7:0]       seconds_left;
    kcl_pkg::t_result pending_status[$];
    int               mismatches;

    function automatic kcl_pkg::t_result advance_lock(input logic is_tick,
                                                      input logic [7:0] key);
        kcl_pkg::t_event  ev;
        kcl_pkg::t_result status;
        ev = kcl_pkg::EV_NONE;
        if (is_tick) begin
            if (lock_mode == kcl_pkg::MODE_LOCKED_OUT) begin
                if (seconds_left != 8'd0) seconds_left--;
                if (seconds_left == 8'd0) begin
                    lock_mode = kcl_pkg::MODE_ENTRY;
                    ev = kcl_pkg::EV_LOCKOUT_OVER;
                end
            end
        end else if (lock_mode != kcl_pkg::MODE_ENTRY) begin
            ev = kcl_pkg::EV_IGNORED;
        end else if (key >= kcl_pkg::KEY_ZERO && key <= kcl_pkg::KEY_NINE) begin
            if (entry_digits >= MAX_DIGITS) begin
                ev = kcl_pkg::EV_IGNORED;
            end else begin
                entry_value = entry_value * 32'd10 + 32'(key - kcl_pkg::KEY_ZERO);
                entry_digits++;
                ev = kcl_pkg::EV_DIGIT;
            end
        end else if (key == kcl_pkg::KEY_ENTER) begin
            if (entry_value == lock_cfg.secret_code) begin
                misses = 3'd0;
                lock_mode = kcl_pkg::MODE_UNLOCKED;
                ev = kcl_pkg::EV_CORRECT;
            end else begin
                if (misses != kcl_pkg::ATTEMPT_MAX) misses++;
                if (misses == lock_cfg.lockout_attempt) begin
                    seconds_left = lock_cfg.lockout_seconds;
                    lock_mode = kcl_pkg::MODE_LOCKED_OUT;
                    ev = kcl_pkg::EV_LOCKOUT;
                end else if (misses >= lock_cfg.alarm_attempt) begin
                    lock_mode = kcl_pkg::MODE_ALARM;
                    ev = kcl_pkg::EV_ALARM;
                end else begin
                    ev = kcl_pkg::EV_WRONG;
                end
            end
            entry_value = 32'd0;
            entry_digits = 5'd0;
        end else begin
            ev = kcl_pkg::EV_IGNORED;
        end
        if (lock_mode != kcl_pkg::MODE_LOCKED_OUT) seconds_left = 8'd0;
        status.event_res         = ev;
        status.is_unlocked       = (lock_mode == kcl_pkg::MODE_UNLOCKED);
        status.alarm_on          = (lock_mode == kcl_pkg::MODE_ALARM);
        status.is_locked_out     = (lock_mode == kcl_pkg::MODE_LOCKED_OUT);
        status.seconds_remaining = seconds_left;
        status.attempt_count     = misses;
        return status;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        kcl_pkg::t_result want;
        kcl_pkg::t_result got;
        if (!i_rst_n) begin
            lock_cfg.secret_code     = kcl_pkg::SECRET_CODE_RST;
            lock_cfg.lockout_seconds = kcl_pkg::LOCKOUT_SECONDS_RST;
            lock_cfg.lockout_attempt = kcl_pkg::LOCKOUT_ATTEMPT_RST;
            lock_cfg.alarm_attempt   = kcl_pkg::ALARM_ATTEMPT_RST;
            lock_mode    = kcl_pkg::MODE_ENTRY;
            entry_value  = 32'd0;
            entry_digits = 5'd0;
            misses       = 3'd0;
            seconds_left = 8'd0;
            pending_status.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                unique case (kcl_pkg::t_reg_idx'(i_paddr[3:2]))
                    kcl_pkg::REG_SECRET_CODE:
                        lock_cfg.secret_code = i_pwdata;
                    kcl_pkg::REG_LOCKOUT_SECONDS:
                        lock_cfg.lockout_seconds = i_pwdata[7:0];
                    kcl_pkg::REG_LOCKOUT_ATTEMPT:
                        lock_cfg.lockout_attempt = i_pwdata[2:0];
                    kcl_pkg::REG_ALARM_ATTEMPT:
                        lock_cfg.alarm_attempt = i_pwdata[2:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = kcl_pkg::t_result'(i_out_data[$bits(kcl_pkg::t_result)-1:0]);
                if (pending_status.size() == 0) begin
                    $error("result word with no expectation: %h", i_out_data);
                    mismatches++;
                end else begin
                    want = pending_status.pop_front();
                    check_field("event_res", want.event_res, got.event_res);
                    check_field("is_unlocked", want.is_unlocked, got.is_unlocked);
                    check_field("alarm_on", want.alarm_on, got.alarm_on);
                    check_field("is_locked_out", want.is_locked_out, got.is_locked_out);
                    check_field("seconds_remaining", want.seconds_remaining,
                                got.seconds_remaining);
                    check_field("attempt_count", want.attempt_count, got.attempt_count);
                    check_field("padding", 0,
                                i_out_data[kcl_pkg::OUT_TDATA_W-1:$bits(kcl_pkg::t_result)]);
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_status.push_back(advance_lock(i_in_user, i_in_data));
            end
        end
        o_pending <= pending_status.size();
        o_errors  <= mismatches;
    end

    initial begin
        mismatches = 0;
    end

endmodule

/* sim/tb.sv */
// Testbench top for the keypad code lock: clock, reset, stimulus, back-pressure and verdict.
module tb;

    localparam int unsigned MAX_DIGITS     = 16;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          LONG_HOLD      = 250;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata  = 8'd0;
    logic                            s_axis_tuser  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [kcl_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            psel          = 1'b0;
    logic                            penable       = 1'b0;
    logic                            pwrite        = 1'b0;
    logic [3:0]                      paddr         = 4'd0;
    logic [31:0]                     pwdata        = 32'd0;
    logic [31:0]                     prdata;
    logic                            pready;

    int pending;
    int errors;
    int burst_left   = 0;
    bit sender_gaps  = 1'b1;
    int idle_cycles  = 0;
    int in_words     = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int mode_left    = 0;
    int ready_mode   = 0;

    always #5 i_clk = ~i_clk;

    keypad_code_lock_unit #(.MAX_DIGITS(MAX_DIGITS)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    kcl_checker #(.MAX_DIGITS(MAX_DIGITS)) i_lock_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    // Receiver: changing ready patterns, plus one long hold-off while the sender keeps going.
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) in_words <= in_words + 1;
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && in_words >= 400) begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
            m_axis_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(20, 120);
            end else begin
                mode_left <= mode_left - 1;
            end
            unique case (ready_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 1) == 0);
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("keypad_code_lock_unit regression: fail");
            $finish;
        end
    end

    task automatic put_word(input logic is_tick, input logic [7:0] key);
        int gap;
        if (burst_left == 0) begin
            if (sender_gaps) begin
                gap = $urandom_range(1, 8);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tuser  <= is_tick;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input kcl_pkg::t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mix of ticks, stray keys and code attempts; enter_budget < 0 means no limit on '='.
    task automatic run_traffic(input int n_words, input int tick_pct, input int enter_budget);
        int sent;
        int len;
        int k;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(0, 99) < tick_pct) begin
                put_word(1'b1, 8'($urandom()));
                sent++;
            end else if ($urandom_range(0, 7) == 0) begin
                put_word(1'b0, 8'($urandom()));
                sent++;
            end else begin
                case ($urandom_range(0, 9))
                    0: len = 0;
                    1: len = $urandom_range(15, 20);
                    default: len = $urandom_range(1, 10);
                endcase
                for (k = 0; k < len; k++) begin
                    put_word(1'b0, kcl_pkg::KEY_ZERO + 8'($urandom_range(0, 9)));
                    sent++;
                end
                if (enter_budget != 0) begin
                    put_word(1'b0, kcl_pkg::KEY_ENTER);
                    sent++;
                    enter_budget--;
                end
            end
        end
    endtask

    initial begin
        int          d;
        int          sub;
        logic [31:0] junk;
        logic [31:0] code;
        logic [31:0] v;
        logic [7:0]  seconds;
        logic [7:0]  code_keys[$];

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: stray keys, all digits, digit overflow, two misses, then a lockout.
        put_word(1'b1, 8'($urandom()));
        put_word(1'b0, 8'h00);
        put_word(1'b0, 8'hff);
        put_word(1'b0, kcl_pkg::KEY_ZERO - 8'd1);
        put_word(1'b0, kcl_pkg::KEY_NINE + 8'd1);
        for (d = 0; d < 10; d++) put_word(1'b0, kcl_pkg::KEY_ZERO + 8'(d));
        repeat (7) put_word(1'b0, kcl_pkg::KEY_NINE);
        repeat (3) put_word(1'b0, kcl_pkg::KEY_ENTER);
        put_word(1'b0, kcl_pkg::KEY_ZERO);
        wait_idle();

        junk = $urandom();
        write_reg(kcl_pkg::REG_SECRET_CODE, $urandom());
        write_reg(kcl_pkg::REG_LOCKOUT_SECONDS, {junk[31:8], 8'd0});
        write_reg(kcl_pkg::REG_LOCKOUT_ATTEMPT, {junk[31:3], 3'd5});
        write_reg(kcl_pkg::REG_ALARM_ATTEMPT, {junk[31:3], 3'd7});
        run_traffic(40, 50, 2);
        wait_idle();

        // From here every miss at the saturated count restarts the lockout.
        write_reg(kcl_pkg::REG_LOCKOUT_ATTEMPT, 32'd7);
        write_reg(kcl_pkg::REG_ALARM_ATTEMPT, 32'd7);
        for (sub = 0; sub < 7; sub++) begin
            wait_idle();
            junk = $urandom();
            if (sub == 3) seconds = 8'd255;
            else if (sub == 5) seconds = 8'd1;
            else seconds = 8'($urandom_range(1, 6));
            write_reg(kcl_pkg::REG_LOCKOUT_SECONDS, {junk[31:8], seconds});
            if (sub == 2) write_reg(kcl_pkg::REG_SECRET_CODE, 32'hffff_ffff);
            else if (sub % 2 == 0) write_reg(kcl_pkg::REG_SECRET_CODE, $urandom());
            sender_gaps = ($urandom_range(0, 3) != 0);
            run_traffic((sub == 3) ? 300 : 100, (sub == 3) ? 75 : 35, -1);
        end

        sender_gaps = 1'b1;
        repeat (64) put_word(1'b1, 8'($urandom()));
        put_word(1'b0, kcl_pkg::KEY_ENTER);
        repeat (64) put_word(1'b1, 8'($urandom()));
        wait_idle();

        if ($urandom_range(0, 1) == 0) begin
            write_reg(kcl_pkg::REG_SECRET_CODE, 32'hffff_ffff);
            write_reg(kcl_pkg::REG_LOCKOUT_ATTEMPT, 32'd0);
            write_reg(kcl_pkg::REG_ALARM_ATTEMPT, 32'd0);
            put_word(1'b0, kcl_pkg::KEY_ZERO + 8'd1);
            put_word(1'b0, kcl_pkg::KEY_ENTER);
        end else begin
            case ($urandom_range(0, 2))
                0: code = 32'd0;
                1: code = 32'hffff_ffff;
                default: code = $urandom();
            endcase
            write_reg(kcl_pkg::REG_SECRET_CODE, code);
            if (code != 32'd0 || $urandom_range(0, 1) == 0) begin
                v = code;
                do begin
                    code_keys.push_front(kcl_pkg::KEY_ZERO + 8'(v % 10));
                    v = v / 10;
                end while (v != 32'd0);
            end
            foreach (code_keys[idx]) put_word(1'b0, code_keys[idx]);
            put_word(1'b0, kcl_pkg::KEY_ENTER);
        end
        run_traffic(60, 50, -1);

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("keypad_code_lock_unit regression: pass");
        end else begin
            $display("keypad_code_lock_unit regression: fail");
        end
        $finish;
    end

endmodule

/* files.f */
design/kcl_pkg.sv
design/kcl_cfg_regs.sv
design/kcl_core.sv
design/keypad_code_lock_unit.sv
sim/kcl_checker.sv
sim/tb.sv
